/* src/repeating_timer_table_unit_defines.svh */
// Assertion macros shared by the timer table RTL.
// Included by repeating_timer_table_unit.sv; needs aclk and aresetn in scope.
`ifndef REPEATING_TIMER_TABLE_UNIT_DEFINES_SVH
`define REPEATING_TIMER_TABLE_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// condition must hold on every clock out of reset
`define RTT_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("rtt assertion failed");
// antecedent implies consequent in the same cycle
`define RTT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("rtt implication failed");
`else
`define RTT_ASSERT(lbl, cond)
`define RTT_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

/* src/rtt_pkg.sv */
// Shared types and constants for the repeating timer table.
// No dependencies; imported by every module of the block.
package rtt_pkg;

    localparam int DEPTH      = 16;
    localparam int TIME_WIDTH = 16;
    localparam int ELAP_W     = TIME_WIDTH + 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int FC_W       = 16;
    localparam int TAG_W      = 16;
    localparam int INC_W      = 16;
    localparam int SUM_W      = ((ELAP_W > INC_W) ? ELAP_W : INC_W) + 1;
    localparam int PADDR_W    = 3;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;
    localparam logic [1:0] MODE_QUERY  = 2'd3;

    localparam logic [INC_W-1:0] INC_RESET = INC_W'(1);

    typedef struct packed {
        logic [TIME_WIDTH-1:0] period;
        logic [FC_W-1:0]       rep;
        logic [TAG_W-1:0]      tag;
        logic [ELAP_W-1:0]     elapsed;
        logic [FC_W-1:0]       fcnt;
    } entry_t;

    typedef struct packed {
        logic fire;
        logic keep;
        logic match;
    } head_flags_t;

endpackage

/* src/rtt_cell.sv */
// One timer table cell: holds an entry, shifts from its upper neighbor
// or takes a new entry. Depends on rtt_pkg.
module rtt_cell (
    input  logic           aclk,
    input  logic           i_shift,
    input  logic           i_load,
    input  rtt_pkg::entry_t i_nbr,
    input  rtt_pkg::entry_t i_load_data,
    output rtt_pkg::entry_t o_entry
);
    import rtt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    // load wins over shift; otherwise hold
    always_comb begin
        entry_next = entry_reg;
        if (i_load) begin
            entry_next = i_load_data;
        end else if (i_shift) begin
            entry_next = i_nbr;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign o_entry = entry_reg;

endmodule

/* src/rtt_head.sv */
// Head unit: updates the entry leaving cell 0 during a walk and decides
// whether it fires, matches the tag and stays. Depends on rtt_pkg.
module rtt_head (
    input  rtt_pkg::entry_t     i_entry,
    input  logic [1:0]          i_mode,
    input  logic [rtt_pkg::TAG_W-1:0] i_tag,
    input  logic [rtt_pkg::INC_W-1:0] i_inc,
    input  logic                i_hit,
    output rtt_pkg::entry_t     o_entry,
    output rtt_pkg::head_flags_t o_flags
);
    import rtt_pkg::*;

    logic [SUM_W-1:0]  sum;
    logic [ELAP_W-1:0] e_sat;
    logic              fire;
    logic [FC_W-1:0]   fc_new;
    logic              match;

    always_comb begin
        // saturating elapsed-time add
        sum   = SUM_W'(i_entry.elapsed) + SUM_W'(i_inc);
        e_sat = (sum > SUM_W'({ELAP_W{1'b1}})) ? {ELAP_W{1'b1}} : ELAP_W'(sum);
        fire  = (e_sat >= ELAP_W'(i_entry.period));
        fc_new = (fire && (i_entry.fcnt != {FC_W{1'b1}})) ? i_entry.fcnt + FC_W'(1)
                                                         : i_entry.fcnt;
        match = (i_entry.tag == i_tag) && !i_hit;

        o_entry = i_entry;
        o_flags = '0;
        case (i_mode)
            MODE_TICK: begin
                o_entry.elapsed = fire ? '0 : e_sat;
                o_entry.fcnt    = fc_new;
                o_flags.fire    = fire;
                o_flags.keep    = (fc_new < i_entry.rep);
            end
            MODE_REMOVE: begin
                o_flags.match = match;
                o_flags.keep  = !match;
            end
            MODE_QUERY: begin
                o_flags.match = match;
                o_flags.keep  = 1'b1;
            end
            default: begin
                o_flags.keep = 1'b1;
            end
        endcase
    end

endmodule

/* src/repeating_timer_table_unit.sv */
// Repeating timer table: an add writes the new entry into the next free cell; tick, remove
// and query walk the stored entries through the head unit, one walk step per stored entry,
// and wait while the result port stalls. One word is in flight at a time.
// Ticks emit one result word per fired timer, or a single word when none fires, at most DEPTH.
// Synchronous active-low reset empties the table and sets tick_increment to 1.
`include "repeating_timer_table_unit_defines.svh"
module repeating_timer_table_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [rtt_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // period[15:0], repeat_count[31:16], tag[47:32]
    input  logic [1:0]  s_tuser,   // mode[1:0]
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // fired[0], fired_tag[16:1], found[17], add_ok[18], zero pad
    output logic        m_tlast
);
    import rtt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [INC_W-1:0]  inc_reg, inc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  top_reg, top_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [1:0]        mode_reg, mode_next;
    logic [TAG_W-1:0]  tag_reg, tag_next;
    logic              hit_reg, hit_next;
    logic              addok_reg, addok_next;
    logic              pend_v_reg, pend_v_next;
    logic [TAG_W-1:0]  pend_tag_reg, pend_tag_next;
    logic              mv_reg, mv_next;
    logic [23:0]       md_reg, md_next;
    logic              ml_reg, ml_next;

    entry_t            cells [DEPTH];
    entry_t            nbr [DEPTH];
    entry_t            head_out;
    entry_t            new_entry;
    entry_t            load_data;
    head_flags_t       hflags;
    logic              shift_en;
    logic              load_en;
    logic [IDX_W-1:0]  load_idx;

    logic              accept;
    logic              out_free;
    logic              step_go;
    logic              out_load;
    logic              o_fired, o_found, o_addok, o_last;
    logic [TAG_W-1:0]  o_tag;

    // config write and read
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1] == 1'b0);
    assign prdata = (paddr[PADDR_W-1] == 1'b0) ? 32'(inc_reg) : 32'd0;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !mv_reg || m_tready;

    // entry built from an add word
    always_comb begin
        new_entry.period  = TIME_WIDTH'(s_tdata[15:0]);
        new_entry.rep     = s_tdata[31:16];
        new_entry.tag     = s_tdata[47:32];
        new_entry.elapsed = '0;
        new_entry.fcnt    = '0;
    end

    rtt_head u_head (
        .i_entry (cells[0]),
        .i_mode  (mode_reg),
        .i_tag   (tag_reg),
        .i_inc   (inc_reg),
        .i_hit   (hit_reg),
        .o_entry (head_out),
        .o_flags (hflags)
    );

    // row of cells, each shifting toward cell 0
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        if (gi == DEPTH - 1) begin : g_end
            assign nbr[gi] = cells[gi];
        end else begin : g_mid
            assign nbr[gi] = cells[gi+1];
        end
        rtt_cell u_cell (
            .aclk        (aclk),
            .i_shift     (shift_en),
            .i_load      (load_en && (load_idx == IDX_W'(gi))),
            .i_nbr       (nbr[gi]),
            .i_load_data (load_data),
            .o_entry     (cells[gi])
        );
    end

    // control and result sequencing
    always_comb begin
        state_next    = state_reg;
        inc_next      = cfg_wr ? pwdata[INC_W-1:0] : inc_reg;
        cnt_next      = cnt_reg;
        top_next      = top_reg;
        k_next        = k_reg;
        mode_next     = mode_reg;
        tag_next      = tag_reg;
        hit_next      = hit_reg;
        addok_next    = addok_reg;
        pend_v_next   = pend_v_reg;
        pend_tag_next = pend_tag_reg;
        shift_en      = 1'b0;
        load_en       = 1'b0;
        load_idx      = IDX_W'(top_reg - CNT_W'(1));
        load_data     = head_out;
        step_go       = 1'b0;
        out_load      = 1'b0;
        o_fired       = 1'b0;
        o_tag         = '0;
        o_found       = 1'b0;
        o_addok       = 1'b0;
        o_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    mode_next  = s_tuser;
                    tag_next   = s_tdata[47:32];
                    hit_next   = 1'b0;
                    addok_next = 1'b0;
                    k_next     = '0;
                    top_next   = cnt_reg;
                    if (s_tuser == MODE_ADD) begin
                        if (cnt_reg < CNT_W'(DEPTH)) begin
                            load_en    = 1'b1;
                            load_idx   = IDX_W'(cnt_reg);
                            load_data  = new_entry;
                            top_next   = cnt_reg + CNT_W'(1);
                            addok_next = 1'b1;
                        end
                        state_next = ST_DONE;
                    end else if (cnt_reg == '0) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK: begin
                step_go = !(hflags.fire && pend_v_reg) || out_free;
                if (step_go) begin
                    shift_en = 1'b1;
                    load_en  = hflags.keep;
                    if (!hflags.keep) begin
                        top_next = top_reg - CNT_W'(1);
                    end
                    if (hflags.match) begin
                        hit_next = 1'b1;
                    end
                    // a new firing flushes the held one as a non-final word
                    if (hflags.fire) begin
                        if (pend_v_reg) begin
                            out_load = 1'b1;
                            o_fired  = 1'b1;
                            o_tag    = pend_tag_reg;
                        end
                        pend_v_next   = 1'b1;
                        pend_tag_next = cells[0].tag;
                    end
                    k_next = k_reg + CNT_W'(1);
                    if (k_reg == cnt_reg - CNT_W'(1)) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    o_last      = 1'b1;
                    o_fired     = pend_v_reg;
                    o_tag       = pend_v_reg ? pend_tag_reg : '0;
                    o_found     = hit_reg;
                    o_addok     = addok_reg;
                    pend_v_next = 1'b0;
                    cnt_next    = top_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        mv_next = mv_reg;
        md_next = md_reg;
        ml_next = ml_reg;
        if (out_load) begin
            mv_next = 1'b1;
            md_next = {5'd0, o_addok, o_found, o_tag, o_fired};
            ml_next = o_last;
        end else if (m_tready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            inc_reg    <= INC_RESET;
            cnt_reg    <= '0;
            top_reg    <= '0;
            k_reg      <= '0;
            hit_reg    <= 1'b0;
            addok_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            inc_reg    <= inc_next;
            cnt_reg    <= cnt_next;
            top_reg    <= top_next;
            k_reg      <= k_next;
            hit_reg    <= hit_next;
            addok_reg  <= addok_next;
            pend_v_reg <= pend_v_next;
            mv_reg     <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg     <= mode_next;
        tag_reg      <= tag_next;
        pend_tag_reg <= pend_tag_next;
        md_reg       <= md_next;
        ml_reg       <= ml_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;

    // checks
    `RTT_ASSERT(a_cnt_range, cnt_reg <= CNT_W'(DEPTH))
    `RTT_ASSERT_IMPL(a_idle_no_pend, state_reg == ST_IDLE, !pend_v_reg)
    `RTT_ASSERT_IMPL(a_walk_top, state_reg == ST_WALK, top_reg <= cnt_reg && k_reg < cnt_reg)

endmodule
